>>> rtl/bsir_pkg.sv
`default_nettype none
package bsir_pkg;

  localparam int unsigned CAPACITY_DEF      = 32;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;
  localparam int unsigned PADDR_W           = 3;
  localparam int unsigned PDATA_W           = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ALLOW_DUP = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RANGE  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RANGE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [5:0]         range_first;
    logic [5:0]         range_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         fill_count;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/bounded_set_insert_remove_range_core.sv
// insert with duplicates allowed, full table or empty range: straight to the response state
// search (remove, or insert with duplicates disallowed): a scan over the stored entries, plus
// compaction of the entries behind the removed entry; one read port sets the pace
// range read: first word read and registered, then one word per cycle while out_ready_i holds
// one item at a time, input reopens after the last word loads; an unused opcode is dropped
// reset: fill count clears and allow_duplicates sets to 1; table contents stay undefined
`default_nettype none
module bounded_set_insert_remove_range_core #(
  parameter int unsigned CAPACITY      = bsir_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = bsir_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  bsir_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output bsir_pkg::out_word_t            out_data_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [bsir_pkg::PADDR_W-1:0]   paddr,
  input  wire  [bsir_pkg::PDATA_W-1:0]   pwdata,
  output logic [bsir_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import bsir_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > 6) ? CW : 6;
  localparam int unsigned EW = ELEMENT_WIDTH;

  // table memory
  logic [EW-1:0] mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rd_data_q;

  state_e        state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] loc_q, loc_d;
  logic          found_q, found_d;
  logic          is_remove_q, is_remove_d;
  logic [EW-1:0] val_q, val_d;
  logic [CW-1:0] stop_q, stop_d;
  status_e       res_q, res_d;
  logic [CW-1:0] count_q, count_d;
  logic          allow_dup_q;
  logic          out_valid_q;
  out_word_t     out_q, out_d;
  logic          out_load;

  logic          slot_free;
  logic          match;
  logic          scan_last;
  logic [AW-1:0] loc_fin;
  logic [EW-1:0] in_store;
  logic [EW+31:0] rd_ext;
  logic [63:0]   in_ext;
  logic [MW-1:0] stop_calc;
  logic          cfg_wr;

  assign in_ext    = {{32{in_data_i.value[31]}}, in_data_i.value};
  assign in_store  = in_ext[EW-1:0];
  assign rd_ext    = {{32{rd_data_q[EW-1]}}, rd_data_q};
  assign slot_free = !out_valid_q || out_ready_i;
  assign match     = (rd_data_q == val_q);
  assign scan_last = (CW'(ptr_q) == count_q - CW'(1));
  assign loc_fin   = match ? ptr_q : loc_q;
  assign stop_calc = (MW'(in_data_i.range_end) < MW'(count_q)) ?
                     MW'(in_data_i.range_end) : MW'(count_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ALLOW_DUP) begin
      prdata[0] = allow_dup_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    loc_d       = loc_q;
    found_d     = found_q;
    is_remove_d = is_remove_q;
    val_d       = val_q;
    stop_d      = stop_q;
    res_d       = res_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(count_q);
    mem_wdata   = val_q;
    mem_raddr   = ptr_q + AW'(1);
    out_load    = 1'b0;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = '0;
        if (in_valid_i) begin
          val_d   = in_store;
          ptr_d   = '0;
          found_d = 1'b0;
          unique case (in_data_i.opcode)
            OP_INSERT: begin
              is_remove_d = 1'b0;
              if (count_q >= CW'(CAPACITY)) begin
                res_d   = ST_FULL;
                state_d = S_RESP;
              end else if (!allow_dup_q && count_q != '0) begin
                state_d = S_SCAN;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = in_store;
                count_d   = count_q + CW'(1);
                res_d     = ST_OK;
                state_d   = S_RESP;
              end
            end
            OP_REMOVE: begin
              is_remove_d = 1'b1;
              if (count_q == '0) begin
                res_d   = ST_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_RANGE: begin
              if (MW'(in_data_i.range_first) >= stop_calc) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                mem_raddr = AW'(in_data_i.range_first);
                ptr_d     = AW'(in_data_i.range_first);
                stop_d    = CW'(stop_calc);
                state_d   = S_RANGE;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        ptr_d = ptr_q + AW'(1);
        if (!is_remove_q) begin
          if (match) begin
            res_d   = ST_DUPLICATE;
            state_d = S_RESP;
          end else if (scan_last) begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
            res_d   = ST_OK;
            state_d = S_RESP;
          end
        end else begin
          if (match) begin
            loc_d   = ptr_q;
            found_d = 1'b1;
          end
          if (scan_last) begin
            if (!(found_q || match)) begin
              res_d   = ST_NOT_FOUND;
              state_d = S_RESP;
            end else if (CW'(loc_fin) == count_q - CW'(1)) begin
              count_d = count_q - CW'(1);
              res_d   = ST_OK;
              state_d = S_RESP;
            end else begin
              // walk the entries behind the hit down by one
              mem_raddr = loc_fin + AW'(1);
              ptr_d     = loc_fin + AW'(1);
              state_d   = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        mem_wdata = rd_data_q;
        ptr_d     = ptr_q + AW'(1);
        if (scan_last) begin
          count_d = count_q - CW'(1);
          res_d   = ST_OK;
          state_d = S_RESP;
        end
      end

      S_RANGE: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_d.status     = ST_OK;
          out_d.element    = rd_ext[31:0];
          out_d.last       = (CW'(ptr_q) + CW'(1) == stop_q);
          out_d.fill_count = 6'(count_q);
          ptr_d            = ptr_q + AW'(1);
          if (out_d.last) begin
            state_d = S_IDLE;
          end
        end else begin
          // hold the address so the read data stays put
          mem_raddr = ptr_q;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_d.status     = res_q;
          out_d.element    = '0;
          out_d.last       = 1'b1;
          out_d.fill_count = 6'(count_q);
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      allow_dup_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_wr && paddr[2] == REG_ALLOW_DUP) begin
        allow_dup_q <= pwdata[0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    loc_q       <= loc_d;
    found_q     <= found_d;
    is_remove_q <= is_remove_d;
    val_q       <= val_d;
    stop_q      <= stop_d;
    res_q       <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q + CW'(1) == $past(count_q)))
    else $error("fill count moved by more than one");

  a_no_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RANGE || state_q == S_RESP) |-> !mem_we)
    else $error("table written during range read or response");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output word overwritten before taken");

endmodule
`default_nettype wire
